/* rtl/obb_overlap_separating_axis_test_assert.svh */
// Assertion macros used by the checker file.
`ifndef OBB_OVERLAP_SEPARATING_AXIS_TEST_ASSERT_SVH
`define OBB_OVERLAP_SEPARATING_AXIS_TEST_ASSERT_SVH

// Check a property on the rising clock, off while reset is asserted.
`define OBBSAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication on the rising clock, off while reset is asserted.
`define OBBSAT_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

/* rtl/obbsat_pkg.sv */
package obbsat_pkg;

  localparam int CoordBits = 20;
  localparam int FracBits  = 10;

  localparam int FieldW    = 60;
  localparam int NumFields = 10;
  localparam int InDataW   = FieldW * NumFields;
  localparam int OutDataW  = 8;
  localparam int PadW      = (3 * CoordBits > FieldW) ? 3 * CoordBits : FieldW;

  // Register stages from the input transfer to the output register
  localparam int NumStages = 10;

  // Arithmetic widths along the pipeline
  localparam int VecW     = CoordBits + 1;
  localparam int ProdW    = 2 * CoordBits;
  localparam int CrossW   = 2 * CoordBits + 1;
  localparam int PlaneLoW = CoordBits + 1;
  localparam int PartLoW  = 2 * CoordBits + 3;
  localparam int PartHiW  = 2 * CoordBits + 1;
  localparam int TermDotW = 3 * CoordBits + 2;
  localparam int DotW     = 3 * CoordBits + 4;
  localparam int MulLoW   = 32;
  localparam int MulHiW   = DotW - MulLoW;
  localparam int TermW    = DotW + CoordBits;
  localparam int RhsW     = TermW + 3;
  localparam int LhsW     = DotW + FracBits;
  localparam int CmpW     = (RhsW > LhsW) ? RhsW : LhsW;

  localparam int NumAxes  = 15;
  localparam int AxisW    = 4;
  localparam logic [AxisW-1:0] AxisNone = 4'd15;

  // Component idx of a packed field.
  function automatic logic [CoordBits-1:0] get_comp(input logic [FieldW-1:0] f,
                                                    input logic [1:0] idx);
    logic [PadW-1:0] p;
    p = PadW'(f);
    return p[idx * CoordBits +: CoordBits];
  endfunction

endpackage

/* rtl/obb_overlap_separating_axis_test.sv */
// An input transfer passes every stage register up to the output register
// before m_axis_tvalid rises. Throughput: one box pair per cycle unless
// m_axis_tready stalls the output; every stage is a register slice that
// refills as soon as the stage after it moves, so bubbles collapse under stall.
// Reset clears only the stage valid bits; payload registers are not reset.
module obb_overlap_separating_axis_test (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, low to high: box_a_center, box_a_axis_x, box_a_axis_y, box_a_axis_z,
  // box_a_half, box_b_center, box_b_axis_x, box_b_axis_y, box_b_axis_z,
  // box_b_half (60 bits each)
  input  logic [obbsat_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, low to high: overlap (1), first_separating_axis (4), zero fill (3)
  output logic [obbsat_pkg::OutDataW-1:0] m_axis_tdata
);

  // Stage valid bits and load enables: a stage loads when empty or when
  // the stage after it loads.
  logic [obbsat_pkg::NumStages:1] v_q, v_d;
  logic [obbsat_pkg::NumStages:1] en;

  always_comb begin
    en[obbsat_pkg::NumStages] = !v_q[obbsat_pkg::NumStages] || m_axis_tready;
    for (int s = obbsat_pkg::NumStages - 1; s >= 1; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
    v_d = v_q;
    if (en[1]) begin
      v_d[1] = s_axis_tvalid;
    end
    for (int s = 2; s <= obbsat_pkg::NumStages; s++) begin
      if (en[s]) begin
        v_d[s] = v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = v_q[obbsat_pkg::NumStages];

  // ---------------------------------------------------------------------
  // Stage 1: unpack. Vector 0 is the center offset B - A, vectors 1..3 the
  // axes of A, 4..6 the axes of B; all sign extended by one bit.
  // ---------------------------------------------------------------------
  logic signed [obbsat_pkg::VecW-1:0]   s1_vec_d [7][3];
  logic signed [obbsat_pkg::VecW-1:0]   s1_vec_q [7][3];
  logic [obbsat_pkg::CoordBits-1:0]     s1_half_d [6];
  logic [obbsat_pkg::CoordBits-1:0]     s1_half_q [6];

  always_comb begin
    logic [obbsat_pkg::CoordBits-1:0] ca, cb, ax;
    for (int c = 0; c < 3; c++) begin
      ca = obbsat_pkg::get_comp(s_axis_tdata[0 +: obbsat_pkg::FieldW], 2'(c));
      cb = obbsat_pkg::get_comp(s_axis_tdata[5*obbsat_pkg::FieldW +: obbsat_pkg::FieldW],
                                2'(c));
      s1_vec_d[0][c] = $signed({cb[obbsat_pkg::CoordBits-1], cb})
                     - $signed({ca[obbsat_pkg::CoordBits-1], ca});
      for (int a = 0; a < 3; a++) begin
        ax = obbsat_pkg::get_comp(
               s_axis_tdata[(1+a)*obbsat_pkg::FieldW +: obbsat_pkg::FieldW], 2'(c));
        s1_vec_d[1+a][c] = $signed({ax[obbsat_pkg::CoordBits-1], ax});
        ax = obbsat_pkg::get_comp(
               s_axis_tdata[(6+a)*obbsat_pkg::FieldW +: obbsat_pkg::FieldW], 2'(c));
        s1_vec_d[4+a][c] = $signed({ax[obbsat_pkg::CoordBits-1], ax});
      end
      s1_half_d[c]   = obbsat_pkg::get_comp(
                         s_axis_tdata[4*obbsat_pkg::FieldW +: obbsat_pkg::FieldW], 2'(c));
      s1_half_d[3+c] = obbsat_pkg::get_comp(
                         s_axis_tdata[9*obbsat_pkg::FieldW +: obbsat_pkg::FieldW], 2'(c));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_vec_q  <= s1_vec_d;
      s1_half_q <= s1_half_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: the six component products of each cross axis A_i x B_j.
  // ---------------------------------------------------------------------
  logic signed [obbsat_pkg::ProdW-1:0] s2_pr_d [9][6];
  logic signed [obbsat_pkg::ProdW-1:0] s2_pr_q [9][6];
  logic signed [obbsat_pkg::VecW-1:0]  s2_vec_q [7][3];
  logic [obbsat_pkg::CoordBits-1:0]    s2_half_q [6];

  always_comb begin
    logic signed [obbsat_pkg::CoordBits-1:0] a [3];
    logic signed [obbsat_pkg::CoordBits-1:0] b [3];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < 3; c++) begin
          a[c] = $signed(s1_vec_q[1+i][c][obbsat_pkg::CoordBits-1:0]);
          b[c] = $signed(s1_vec_q[4+j][c][obbsat_pkg::CoordBits-1:0]);
        end
        s2_pr_d[3*i+j][0] = a[1] * b[2];
        s2_pr_d[3*i+j][1] = a[2] * b[1];
        s2_pr_d[3*i+j][2] = a[2] * b[0];
        s2_pr_d[3*i+j][3] = a[0] * b[2];
        s2_pr_d[3*i+j][4] = a[0] * b[1];
        s2_pr_d[3*i+j][5] = a[1] * b[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_pr_q   <= s2_pr_d;
      s2_vec_q  <= s1_vec_q;
      s2_half_q <= s1_half_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: the 15 candidate axes at a common width.
  // ---------------------------------------------------------------------
  logic signed [obbsat_pkg::CrossW-1:0] s3_plane_d [obbsat_pkg::NumAxes][3];
  logic signed [obbsat_pkg::CrossW-1:0] s3_plane_q [obbsat_pkg::NumAxes][3];
  logic signed [obbsat_pkg::VecW-1:0]   s3_vec_q [7][3];
  logic [obbsat_pkg::CoordBits-1:0]     s3_half_q [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      for (int c = 0; c < 3; c++) begin
        s3_plane_d[k][c] = obbsat_pkg::CrossW'(s2_vec_q[1+k][c]);
      end
    end
    for (int n = 0; n < 9; n++) begin
      for (int c = 0; c < 3; c++) begin
        s3_plane_d[6+n][c] = obbsat_pkg::CrossW'(s2_pr_q[n][2*c])
                           - obbsat_pkg::CrossW'(s2_pr_q[n][2*c+1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_plane_q <= s3_plane_d;
      s3_vec_q   <= s2_vec_q;
      s3_half_q  <= s2_half_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: partial products of every vector against every axis; the
  // axis component is split into a signed high and an unsigned low part.
  // ---------------------------------------------------------------------
  logic signed [obbsat_pkg::PartLoW-1:0] s4_plo_d [obbsat_pkg::NumAxes][7][3];
  logic signed [obbsat_pkg::PartLoW-1:0] s4_plo_q [obbsat_pkg::NumAxes][7][3];
  logic signed [obbsat_pkg::PartHiW-1:0] s4_phi_d [obbsat_pkg::NumAxes][7][3];
  logic signed [obbsat_pkg::PartHiW-1:0] s4_phi_q [obbsat_pkg::NumAxes][7][3];
  logic [obbsat_pkg::CoordBits-1:0]      s4_half_q [6];

  always_comb begin
    for (int k = 0; k < obbsat_pkg::NumAxes; k++) begin
      for (int v = 0; v < 7; v++) begin
        for (int c = 0; c < 3; c++) begin
          s4_plo_d[k][v][c] = s3_vec_q[v][c]
            * $signed({1'b0, s3_plane_q[k][c][obbsat_pkg::PlaneLoW-1:0]});
          s4_phi_d[k][v][c] = s3_vec_q[v][c]
            * $signed(s3_plane_q[k][c][obbsat_pkg::CrossW-1:obbsat_pkg::PlaneLoW]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_plo_q  <= s4_plo_d;
      s4_phi_q  <= s4_phi_d;
      s4_half_q <= s3_half_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: merge the partials and sum the three components: dot products.
  // ---------------------------------------------------------------------
  logic signed [obbsat_pkg::DotW-1:0] s5_dot_d [obbsat_pkg::NumAxes][7];
  logic signed [obbsat_pkg::DotW-1:0] s5_dot_q [obbsat_pkg::NumAxes][7];
  logic [obbsat_pkg::CoordBits-1:0]   s5_half_q [6];

  always_comb begin
    logic signed [obbsat_pkg::TermDotW-1:0] t [3];
    for (int k = 0; k < obbsat_pkg::NumAxes; k++) begin
      for (int v = 0; v < 7; v++) begin
        for (int c = 0; c < 3; c++) begin
          t[c] = (obbsat_pkg::TermDotW'(s4_phi_q[k][v][c]) <<< obbsat_pkg::PlaneLoW)
               + obbsat_pkg::TermDotW'(s4_plo_q[k][v][c]);
        end
        s5_dot_d[k][v] = obbsat_pkg::DotW'(t[0]) + obbsat_pkg::DotW'(t[1])
                       + obbsat_pkg::DotW'(t[2]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_dot_q  <= s5_dot_d;
      s5_half_q <= s4_half_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: magnitudes of the dot products.
  // ---------------------------------------------------------------------
  logic [obbsat_pkg::DotW-1:0]      s6_abs_d [obbsat_pkg::NumAxes][7];
  logic [obbsat_pkg::DotW-1:0]      s6_abs_q [obbsat_pkg::NumAxes][7];
  logic [obbsat_pkg::CoordBits-1:0] s6_half_q [6];

  always_comb begin
    for (int k = 0; k < obbsat_pkg::NumAxes; k++) begin
      for (int v = 0; v < 7; v++) begin
        s6_abs_d[k][v] = s5_dot_q[k][v][obbsat_pkg::DotW-1]
                       ? (~s5_dot_q[k][v] + obbsat_pkg::DotW'(1))
                       : s5_dot_q[k][v];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_abs_q  <= s6_abs_d;
      s6_half_q <= s5_half_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: scale each projected axis by its half size, in two halves.
  // ---------------------------------------------------------------------
  logic [obbsat_pkg::MulLoW+obbsat_pkg::CoordBits-1:0] s7_mlo_d [obbsat_pkg::NumAxes][6];
  logic [obbsat_pkg::MulLoW+obbsat_pkg::CoordBits-1:0] s7_mlo_q [obbsat_pkg::NumAxes][6];
  logic [obbsat_pkg::MulHiW+obbsat_pkg::CoordBits-1:0] s7_mhi_d [obbsat_pkg::NumAxes][6];
  logic [obbsat_pkg::MulHiW+obbsat_pkg::CoordBits-1:0] s7_mhi_q [obbsat_pkg::NumAxes][6];
  logic [obbsat_pkg::DotW-1:0]                         s7_lhs_q [obbsat_pkg::NumAxes];

  always_comb begin
    for (int k = 0; k < obbsat_pkg::NumAxes; k++) begin
      for (int i = 0; i < 6; i++) begin
        s7_mlo_d[k][i] = s6_abs_q[k][1+i][obbsat_pkg::MulLoW-1:0] * s6_half_q[i];
        s7_mhi_d[k][i] = s6_abs_q[k][1+i][obbsat_pkg::DotW-1:obbsat_pkg::MulLoW]
                       * s6_half_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_mlo_q <= s7_mlo_d;
      s7_mhi_q <= s7_mhi_d;
      for (int k = 0; k < obbsat_pkg::NumAxes; k++) begin
        s7_lhs_q[k] <= s6_abs_q[k][0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 8: merge the halves and add the six extents in pairs.
  // ---------------------------------------------------------------------
  logic [obbsat_pkg::RhsW-1:0] s8_pair_d [obbsat_pkg::NumAxes][3];
  logic [obbsat_pkg::RhsW-1:0] s8_pair_q [obbsat_pkg::NumAxes][3];
  logic [obbsat_pkg::DotW-1:0] s8_lhs_q [obbsat_pkg::NumAxes];

  always_comb begin
    logic [obbsat_pkg::RhsW-1:0] term [6];
    for (int k = 0; k < obbsat_pkg::NumAxes; k++) begin
      for (int i = 0; i < 6; i++) begin
        term[i] = (obbsat_pkg::RhsW'(s7_mhi_q[k][i]) << obbsat_pkg::MulLoW)
                + obbsat_pkg::RhsW'(s7_mlo_q[k][i]);
      end
      for (int p = 0; p < 3; p++) begin
        s8_pair_d[k][p] = term[2*p] + term[2*p+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_pair_q <= s8_pair_d;
      s8_lhs_q  <= s7_lhs_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 9: align the offset projection to the extent scale and compare.
  // Equality does not separate, and an all-zero cross axis gives 0 > 0.
  // ---------------------------------------------------------------------
  logic [obbsat_pkg::NumAxes-1:0] s9_sep_d, s9_sep_q;

  always_comb begin
    logic [obbsat_pkg::CmpW-1:0] lhs, rhs;
    for (int k = 0; k < obbsat_pkg::NumAxes; k++) begin
      lhs = obbsat_pkg::CmpW'(s8_lhs_q[k]) << obbsat_pkg::FracBits;
      rhs = obbsat_pkg::CmpW'(s8_pair_q[k][0]) + obbsat_pkg::CmpW'(s8_pair_q[k][1])
          + obbsat_pkg::CmpW'(s8_pair_q[k][2]);
      s9_sep_d[k] = lhs > rhs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s9_sep_q <= s9_sep_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 10: output register; pick the lowest separating axis.
  // ---------------------------------------------------------------------
  logic [obbsat_pkg::AxisW-1:0] s10_axis_d, s10_axis_q;

  always_comb begin
    s10_axis_d = obbsat_pkg::AxisNone;
    for (int k = obbsat_pkg::NumAxes - 1; k >= 0; k--) begin
      if (s9_sep_q[k]) begin
        s10_axis_d = obbsat_pkg::AxisW'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      s10_axis_q <= s10_axis_d;
    end
  end

  assign m_axis_tdata = {3'b000, s10_axis_q, (s10_axis_q == obbsat_pkg::AxisNone)};

endmodule

/* rtl/obbsat_chk.sv */
`include "obb_overlap_separating_axis_test_assert.svh"

module obbsat_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [obbsat_pkg::OutDataW-1:0] m_axis_tdata
);

  logic out_stall;
  logic flag_ok;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign flag_ok   = (m_axis_tdata[0] == (m_axis_tdata[4:1] == obbsat_pkg::AxisNone))
                  && (m_axis_tdata[7:5] == 3'b000);

  // A held result keeps its value until taken.
  `OBBSAT_ASSERT_IMP(a_out_hold, out_stall, ##1 (m_axis_tvalid && $stable(m_axis_tdata)), "held")

  // Overlap is set exactly when no axis was found; fill bits stay zero.
  `OBBSAT_ASSERT_IMP(a_flag_axis, m_axis_tvalid, flag_ok, "overlap flag and axis disagree")

  // Input back-pressure only when the output register is full and stalled.
  `OBBSAT_ASSERT(a_ready_stall, s_axis_tready || out_stall, "input stalled while pipe can move")

endmodule

bind obb_overlap_separating_axis_test obbsat_chk u_obbsat_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
